// File: src/record_sorter_descending_core_assert.svh
// ----------------------------------------------------------------------------
// record_sorter_descending_core_assert.svh
// Assertion macros for the port-level checker of the record sorter.
// ----------------------------------------------------------------------------
`ifndef RECORD_SORTER_DESCENDING_CORE_ASSERT_SVH
`define RECORD_SORTER_DESCENDING_CORE_ASSERT_SVH

// Check a property at each rising edge, skipped while reset is held.
`define RSD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at each rising edge, reset included.
`define RSD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/rsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsd_pkg
// Types and constants shared by the descending record sorter.
// ----------------------------------------------------------------------------
package rsd_pkg;

    localparam int SCORE_W = 32;
    localparam int AGE_W   = 8;
    localparam int POS_W   = 6;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic        [AGE_W-1:0]   age;
        logic                      last_record;
    } t_in;

    typedef struct packed {
        logic signed [SCORE_W-1:0] sorted_score;
        logic        [AGE_W-1:0]   sorted_age;
        logic        [POS_W-1:0]   arrival_position;
        logic                      last_result;
    } t_out;

    // Classified record handed from the loader to the sorter.
    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic        [AGE_W-1:0]   age;
        logic        [POS_W-1:0]   pos;
        logic                      store;
        logic                      last;
    } t_job;

endpackage

// File: src/rsd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsd_front
// Loader: numbers each incoming record, marks overflow records to drop.
// ----------------------------------------------------------------------------
module rsd_front #(
    parameter int MAX_RECORDS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rsd_pkg::t_in  i_in,
    output logic          o_job_valid,
    input  logic          i_job_ready,
    output rsd_pkg::t_job o_job
);
    import rsd_pkg::*;

    localparam int CNT_W = $clog2(MAX_RECORDS + 1);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             room;

    assign room        = (r_count < CNT_W'(MAX_RECORDS));
    assign o_in_ready  = i_job_ready;
    assign o_job_valid = i_in_valid;

    always_comb begin
        o_job.score = i_in.score;
        o_job.age   = i_in.age;
        o_job.pos   = POS_W'(r_count);
        o_job.store = room;
        o_job.last  = i_in.last_record;
    end

    always_comb begin
        n_count = r_count;
        if (i_in_valid && i_job_ready) begin
            if (i_in.last_record) begin
                n_count = '0;
            end else if (room) begin
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

// File: src/rsd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsd_fifo
// Two-entry queue of classified records between loader and sorter.
// ----------------------------------------------------------------------------
module rsd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  rsd_pkg::t_job i_push,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output rsd_pkg::t_job o_pop
);
    import rsd_pkg::*;

    localparam int DEPTH = 2;

    t_job       r_mem [DEPTH];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_fill;
    logic       push;
    logic       pop;

    assign o_push_ready = (r_fill != 2'(DEPTH));
    assign o_pop_valid  = (r_fill != 2'd0);
    assign o_pop        = r_mem[r_rptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
            if (push && !pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (pop && !push) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

endmodule

// File: src/rsd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsd_back
// Insertion sorter: a row of cells kept in descending score order, one
// record inserted per cycle while jobs arrive, then shifted out from the head one per cycle while the output is ready.
// ----------------------------------------------------------------------------
module rsd_back #(
    parameter int MAX_RECORDS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    output logic          o_job_ready,
    input  rsd_pkg::t_job i_job,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output rsd_pkg::t_out o_out
);
    import rsd_pkg::*;

    localparam int CNT_W = $clog2(MAX_RECORDS + 1);

    localparam logic ST_LOAD  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic                      r_state;
    logic [CNT_W-1:0]          r_cnt;
    logic signed [SCORE_W-1:0] r_score [MAX_RECORDS];
    logic        [AGE_W-1:0]   r_age   [MAX_RECORDS];
    logic        [POS_W-1:0]   r_pos   [MAX_RECORDS];

    logic [MAX_RECORDS-1:0]    keep;
    logic                      take;
    logic                      insert;
    logic                      shift;

    assign o_job_ready = (r_state == ST_LOAD);
    assign take        = i_job_valid && o_job_ready;
    assign insert      = take && i_job.store;
    assign o_out_valid = (r_state == ST_DRAIN);
    assign shift       = o_out_valid && i_out_ready;

    always_comb begin
        o_out.sorted_score     = r_score[0];
        o_out.sorted_age       = r_age[0];
        o_out.arrival_position = r_pos[0];
        o_out.last_result      = (r_cnt == CNT_W'(1));
    end

    // Cell holds its record when occupied and not below the new score.
    always_comb begin
        for (int i = 0; i < MAX_RECORDS; i++) begin
            keep[i] = (CNT_W'(i) < r_cnt) && (r_score[i] >= i_job.score);
        end
    end

    for (genvar gi = 0; gi < MAX_RECORDS; gi++) begin : g_cell
        always_ff @(posedge i_clk) begin
            if (insert && !keep[gi]) begin
                if (gi == 0) begin
                    r_score[gi] <= i_job.score;
                    r_age[gi]   <= i_job.age;
                    r_pos[gi]   <= i_job.pos;
                end else if (keep[(gi == 0) ? 0 : gi - 1]) begin
                    r_score[gi] <= i_job.score;
                    r_age[gi]   <= i_job.age;
                    r_pos[gi]   <= i_job.pos;
                end else begin
                    r_score[gi] <= r_score[(gi == 0) ? 0 : gi - 1];
                    r_age[gi]   <= r_age[(gi == 0) ? 0 : gi - 1];
                    r_pos[gi]   <= r_pos[(gi == 0) ? 0 : gi - 1];
                end
            end else if (shift && (gi < MAX_RECORDS - 1)) begin
                r_score[gi] <= r_score[(gi < MAX_RECORDS - 1) ? gi + 1 : gi];
                r_age[gi]   <= r_age[(gi < MAX_RECORDS - 1) ? gi + 1 : gi];
                r_pos[gi]   <= r_pos[(gi < MAX_RECORDS - 1) ? gi + 1 : gi];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                ST_LOAD: begin
                    if (insert) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                    if (take && i_job.last) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (shift) begin
                        r_cnt <= r_cnt - CNT_W'(1);
                        if (r_cnt == CNT_W'(1)) begin
                            r_state <= ST_LOAD;
                        end
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

endmodule

// File: src/record_sorter_descending_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_sorter_descending_core
// Sorts a set of records by signed Q16.16 score, highest first, equal
// scores in arrival order, and returns them tagged with arrival position.
// ----------------------------------------------------------------------------
// Records are taken one per cycle while a set loads: each goes through a
// two-entry queue into a row of MAX_RECORDS sorting cells, which places it
// by a compare across all cells at once. After the record marked last, the
// set leaves from the head cell one result per cycle while the output is
// ready; during output the queue still takes up to two records of the next
// set before input ready drops. Records beyond MAX_RECORDS in a set are
// dropped, but a dropped last record still closes the set. No clearing
// pass after reset.
module record_sorter_descending_core #(
    parameter int MAX_RECORDS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rsd_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output rsd_pkg::t_out o_out
);
    import rsd_pkg::*;

    t_job front_job;
    logic front_valid;
    logic front_ready;
    t_job back_job;
    logic back_valid;
    logic back_ready;

    rsd_front #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_job_valid (front_valid),
        .i_job_ready (front_ready),
        .o_job       (front_job)
    );

    rsd_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push       (front_job),
        .o_pop_valid  (back_valid),
        .i_pop_ready  (back_ready),
        .o_pop        (back_job)
    );

    rsd_back #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (back_valid),
        .o_job_ready (back_ready),
        .i_job       (back_job),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

// File: src/rsd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsd_checker
// Port-level checks on the result stream of the record sorter.
// ----------------------------------------------------------------------------
`include "record_sorter_descending_core_assert.svh"

module rsd_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input rsd_pkg::t_out o_out
);
    import rsd_pkg::*;

    `RSD_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out), "result changed while stalled")
    `RSD_ASSERT(a_quiet_after_reset, i_clk, i_rst_n, !$past(i_rst_n) |-> !o_out_valid, "result valid straight after reset")
    `RSD_ASSERT(a_descending, i_clk, i_rst_n, o_out_valid && i_out_ready && !o_out.last_result |=> o_out_valid && (o_out.sorted_score <= $past(o_out.sorted_score)), "results not in descending order")
    `RSD_ASSERT_ALWAYS(a_run_ends, i_clk, i_rst_n && o_out_valid && i_out_ready && o_out.last_result |=> !o_out_valid, "results continue past last transaction")

endmodule

bind record_sorter_descending_core rsd_checker u_rsd_checker (.*);

// File: tb/sv/record_sorter_descending_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_sorter_descending_checker
// Watches both channels of the record sorter, ranks each closed set of
// records by signed score (highest first, ties in arrival order) and
// compares every output transaction field by field with that ranking.
// ----------------------------------------------------------------------------
module record_sorter_descending_checker #(
    parameter int MAX_RECORDS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  rsd_pkg::t_in  i_in,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  rsd_pkg::t_out i_out,
    output int            o_errors,
    output int            o_pending,
    output int            o_results,
    output int            o_sets
);
    import rsd_pkg::*;

    logic signed [SCORE_W-1:0] held_score [MAX_RECORDS];
    logic        [AGE_W-1:0]   held_age   [MAX_RECORDS];
    int                        held_count = 0;
    t_out                      ranked_q [$];
    int                        errors  = 0;
    int                        results = 0;
    int                        sets    = 0;

    function automatic void rank_held_set();
        logic signed [SCORE_W-1:0] sc [MAX_RECORDS];
        logic        [AGE_W-1:0]   ag [MAX_RECORDS];
        logic        [POS_W-1:0]   ps [MAX_RECORDS];
        logic signed [SCORE_W-1:0] key_score;
        logic        [AGE_W-1:0]   key_age;
        logic        [POS_W-1:0]   key_pos;
        int                        j;
        t_out                      res;
        for (int i = 0; i < held_count; i++) begin
            sc[i] = held_score[i];
            ag[i] = held_age[i];
            ps[i] = POS_W'(i);
        end
        // shift only past strictly lower scores so ties keep arrival order
        for (int i = 1; i < held_count; i++) begin
            key_score = sc[i];
            key_age   = ag[i];
            key_pos   = ps[i];
            j = i - 1;
            while (j >= 0 && sc[j] < key_score) begin
                sc[j+1] = sc[j];
                ag[j+1] = ag[j];
                ps[j+1] = ps[j];
                j--;
            end
            sc[j+1] = key_score;
            ag[j+1] = key_age;
            ps[j+1] = key_pos;
        end
        for (int i = 0; i < held_count; i++) begin
            res.sorted_score     = sc[i];
            res.sorted_age       = ag[i];
            res.arrival_position = ps[i];
            res.last_result      = (i == held_count - 1);
            ranked_q.push_back(res);
        end
        held_count = 0;
    endfunction

    function automatic void compare_field(input string name, input logic [63:0] exp_v,
                                          input logic [63:0] got_v);
        if (got_v !== exp_v) begin
            errors++;
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v, got_v);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out exp_res;
        if (!i_rst_n) begin
            held_count = 0;
            ranked_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (ranked_q.size() == 0) begin
                    errors++;
                    $display("%0t ns: unexpected transaction, expected none, got score 0x%0h",
                             $time, i_out.sorted_score);
                end else begin
                    exp_res = ranked_q.pop_front();
                    results++;
                    compare_field("sorted_score", 64'(exp_res.sorted_score),
                                  64'(i_out.sorted_score));
                    compare_field("sorted_age", 64'(exp_res.sorted_age), 64'(i_out.sorted_age));
                    compare_field("arrival_position", 64'(exp_res.arrival_position),
                                  64'(i_out.arrival_position));
                    compare_field("last_result", 64'(exp_res.last_result),
                                  64'(i_out.last_result));
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (held_count < MAX_RECORDS) begin
                    held_score[held_count] = i_in.score;
                    held_age[held_count]   = i_in.age;
                    held_count++;
                end
                if (i_in.last_record) begin
                    rank_held_set();
                    sets++;
                end
            end
        end
        o_errors  <= errors;
        o_pending <= ranked_q.size();
        o_results <= results;
        o_sets    <= sets;
    end

endmodule

// File: tb/sv/tb_record_sorter_descending_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_record_sorter_descending_core
// Drives sets of scored records into the descending record sorter under
// several handshake mixes, including a long output hold-off, and reports
// the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_record_sorter_descending_core;
    import rsd_pkg::*;

    localparam int MAX_RECORDS     = 64;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 20;
    localparam int END_CYCLES      = 2 * MAX_RECORDS + 20;

    localparam logic signed [SCORE_W-1:0] SCORE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = 32'sh8000_0000;

    logic i_clk;
    logic i_rst_n     = 1'b0;
    logic in_valid    = 1'b0;
    logic in_ready;
    t_in  in_item     = '0;
    logic out_valid;
    logic out_ready   = 1'b0;
    t_out out_item;

    int   tx_idle_pct   = 0;
    int   rx_stall_pct  = 0;
    bit   hold_off_req  = 1'b0;
    int   records_sent  = 0;
    int   chk_errors;
    int   chk_pending;
    int   chk_results;
    int   chk_sets;

    record_sorter_descending_core #(
        .MAX_RECORDS(MAX_RECORDS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in       (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out      (out_item)
    );

    record_sorter_descending_checker #(
        .MAX_RECORDS(MAX_RECORDS)
    ) ranking_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .i_in_ready (in_ready),
        .i_in       (in_item),
        .i_out_valid(out_valid),
        .i_out_ready(out_ready),
        .i_out      (out_item),
        .o_errors   (chk_errors),
        .o_pending  (chk_pending),
        .o_results  (chk_results),
        .o_sets     (chk_sets)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // output side: random stalls, or a counted hold-off on request
    initial begin
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else begin
                out_ready <= ($urandom_range(99) >= rx_stall_pct);
                @(posedge i_clk);
            end
        end
    end

    function automatic t_in make_record(input logic signed [SCORE_W-1:0] score,
                                        input logic [AGE_W-1:0] age, input logic last);
        t_in rec;
        rec.score       = score;
        rec.age         = age;
        rec.last_record = last;
        return rec;
    endfunction

    function automatic logic signed [SCORE_W-1:0] pick_score();
        int sel;
        int tie;
        sel = $urandom_range(9);
        if (sel < 2) begin
            case ($urandom_range(4))
                0:       return SCORE_MAX;
                1:       return SCORE_MIN;
                2:       return '0;
                3:       return -1;
                default: return 1;
            endcase
        end else if (sel < 5) begin
            tie = int'($urandom_range(4)) - 2;
            return tie * 65536;
        end
        return $urandom;
    endfunction

    task automatic offer(input t_in rec);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= rec;
        do @(posedge i_clk); while (!in_ready);
        records_sent++;
    endtask

    task automatic send_set(input int size);
        for (int k = 0; k < size; k++)
            offer(make_record(pick_score(), AGE_W'($urandom_range(255)), k == size - 1));
    endtask

    task automatic random_sets(input int budget);
        int sent;
        int size;
        sent = 0;
        while (sent < budget) begin
            size = $urandom_range(1, 8);
            send_set(size);
            sent += size;
        end
    endtask

    task automatic settle(input int tail);
        in_valid <= 1'b0;
        do @(posedge i_clk); while (chk_pending != 0);
        repeat (tail) @(posedge i_clk);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single-record set
        offer(make_record('0, 8'd0, 1'b1));
        // extremes, ties at the top and at -1, sign boundary
        offer(make_record(SCORE_MAX, 8'd255, 1'b0));
        offer(make_record(SCORE_MIN, 8'd0, 1'b0));
        offer(make_record('0, 8'd1, 1'b0));
        offer(make_record(-1, 8'd2, 1'b0));
        offer(make_record(1, 8'd3, 1'b0));
        offer(make_record(SCORE_MAX, 8'd4, 1'b0));
        offer(make_record(-1, 8'd5, 1'b0));
        offer(make_record(32'sh0001_0000, 8'd128, 1'b1));
        // equal pair
        offer(make_record(32'shFFFF_8000, 8'd10, 1'b0));
        offer(make_record(32'shFFFF_8000, 8'd20, 1'b1));
        // ascending run, every pair swapped
        for (int k = 0; k < 5; k++)
            offer(make_record((k - 2) * 65536, AGE_W'(k + 30), k == 4));

        // overfull set: last two records dropped, dropped last still closes
        send_set(MAX_RECORDS + 2);
        // exactly full set
        send_set(MAX_RECORDS);
        random_sets(10);
        settle(SETTLE_CYCLES);

        tx_idle_pct = 76;
        random_sets(25);
        settle(SETTLE_CYCLES);

        tx_idle_pct  = 0;
        rx_stall_pct = 76;
        random_sets(25);
        settle(SETTLE_CYCLES);

        tx_idle_pct  = 8;
        rx_stall_pct = 8;
        random_sets(25);
        settle(SETTLE_CYCLES);

        // hold the output while the input keeps offering
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_off_req = 1'b1;
        for (int s = 0; s < 4; s++)
            send_set(5);
        settle(END_CYCLES);

        $display("Summary: %0d records offered in %0d sets, %0d ranked transactions checked,",
                 records_sent, chk_sets, chk_results);
        $display("set sizes from one record to past capacity, four handshake mixes, one hold-off");
        if (chk_errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/rsd_pkg.sv
src/rsd_front.sv
src/rsd_fifo.sv
src/rsd_back.sv
src/record_sorter_descending_core.sv
src/rsd_checker.sv
tb/sv/record_sorter_descending_checker.sv
tb/sv/tb_record_sorter_descending_core.sv
